// ===== hw/rtl/xtea_pkg.sv =====
package xtea_pkg;

	localparam int WORD_W        = 32;
	localparam int NUM_KEY_WORDS = 4;
	localparam int KEY_IDX_W     = $clog2(NUM_KEY_WORDS);

	// Number of XTEA rounds; each round is two half-rounds, one pipeline stage each.
	localparam int CYCLE_COUNT = 32;
	localparam int NUM_STAGES  = 2 * CYCLE_COUNT;

	localparam logic [WORD_W-1:0] DELTA = 32'h9e3779b9;

	localparam logic DIR_ENCIPHER = 1'b0;
	localparam logic DIR_DECIPHER = 1'b1;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [NUM_KEY_WORDS-1:0][WORD_W-1:0] key_set_t;

	typedef struct packed {
		logic  valid;
		logic  dir;
		word_t v0;
		word_t v1;
	} blk_t;

	// Running sum seen by half-round r when enciphering.
	function automatic word_t enc_sum(int r);
		word_t cnt;
		cnt = WORD_W'((r / 2) + (r % 2));
		return cnt * DELTA;
	endfunction

	// Running sum seen by half-round r when deciphering.
	function automatic word_t dec_sum(int r);
		word_t cnt;
		cnt = WORD_W'(CYCLE_COUNT - (r / 2) - (r % 2));
		return cnt * DELTA;
	endfunction

endpackage

// ===== hw/rtl/xtea_round.sv =====
module xtea_round
	import xtea_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     advance,
	input  logic     odd_stage,
	input  word_t    sum_enc,
	input  word_t    sum_dec,
	input  key_set_t key,
	input  blk_t     blk_in,
	output blk_t     blk_out
);

	logic                 upd_v1;
	word_t                sum;
	logic [KEY_IDX_W-1:0] sel;
	word_t                key_term;
	word_t                src;
	word_t                tgt;
	word_t                mix;
	word_t                f;
	word_t                new_word;
	logic                 vld_s1;
	logic                 dir_s1;
	word_t                v0_s1;
	word_t                v1_s1;

	// Enciphering updates v0 on even and v1 on odd half-rounds; deciphering the reverse.
	assign upd_v1   = odd_stage ^ blk_in.dir;
	assign sum      = (blk_in.dir == DIR_DECIPHER) ? sum_dec : sum_enc;
	assign sel      = upd_v1 ? sum[11 +: KEY_IDX_W] : sum[KEY_IDX_W-1:0];
	assign key_term = sum + key[sel];
	assign src      = upd_v1 ? blk_in.v0 : blk_in.v1;
	assign tgt      = upd_v1 ? blk_in.v1 : blk_in.v0;
	assign mix      = ((src << 4) ^ (src >> 5)) + src;
	assign f        = mix ^ key_term;
	assign new_word = (blk_in.dir == DIR_DECIPHER) ? (tgt - f) : (tgt + f);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= blk_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			dir_s1 <= blk_in.dir;
			v0_s1  <= upd_v1 ? blk_in.v0 : new_word;
			v1_s1  <= upd_v1 ? new_word : blk_in.v1;
		end
	end

	assign blk_out = '{valid: vld_s1, dir: dir_s1, v0: v0_s1, v1: v1_s1};

endmodule

// ===== hw/rtl/xtea_skid.sv =====
module xtea_skid
	import xtea_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  blk_t  up_blk,
	output logic  up_ready,
	output logic  out_valid,
	input  logic  out_ready,
	output word_t out_v0,
	output word_t out_v1
);

	logic  out_v_q;
	word_t out_v0_q;
	word_t out_v1_q;
	logic  sk_v_q;
	word_t sk_v0_q;
	word_t sk_v1_q;

	assign up_ready = !sk_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sk_v_q  <= 1'b0;
		end else if (out_ready || !out_v_q) begin
			if (sk_v_q) begin
				out_v_q <= 1'b1;
				sk_v_q  <= 1'b0;
			end else begin
				out_v_q <= up_blk.valid;
			end
		end else if (up_blk.valid && !sk_v_q) begin
			sk_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_v_q) begin
			if (sk_v_q) begin
				out_v0_q <= sk_v0_q;
				out_v1_q <= sk_v1_q;
			end else begin
				out_v0_q <= up_blk.v0;
				out_v1_q <= up_blk.v1;
			end
		end else if (up_blk.valid && !sk_v_q) begin
			sk_v0_q <= up_blk.v0;
			sk_v1_q <= up_blk.v1;
		end
	end

	assign out_valid = out_v_q;
	assign out_v0    = out_v0_q;
	assign out_v1    = out_v1_q;

	// The spare register only ever holds an item behind one that is already on offer.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q |-> out_v_q)
		else $error("skid holds data while output is empty");

	// The spare register fills only when the output was stalled.
	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sk_v_q) |-> $past(out_v_q && !out_ready))
		else $error("skid filled without an output stall");

	// A parked item is not dropped while the receiver keeps stalling.
	a_skid_kept: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q && !out_ready |=> sk_v_q && $stable(sk_v0_q) && $stable(sk_v1_q))
		else $error("skid contents lost during stall");

endmodule

// ===== hw/rtl/xtea_block_cipher_core.sv =====
// XTEA block cipher core, 64-bit block, 128-bit key, 32 rounds of two half-rounds.
//
// Input channel (in_valid / in_ready): one transaction carries a block as
// block_word_0 / block_word_1 and a direction bit (0 encipher, 1 decipher).
// Output channel (out_valid / out_ready): one transaction per input block,
// carrying result_word_0 / result_word_1 in the order the blocks went in.
// Key words are written through cfg_wr_en / cfg_index / cfg_data; write
// them only while no block is in flight.
//
// Each half-round is one pipeline stage, so there are 64 round stages. A new
// block can be accepted on every clock while the skid register is empty, so
// throughput is one block per cycle.
//
// Reset clears the key to zero and empties the pipeline. When the receiver
// stalls, the result stays in the output register and one more result parks
// in a skid register; only once that skid register is full does in_ready drop
// and the whole pipeline freeze in place, so nothing is lost or repeated.
module xtea_block_cipher_core
	import xtea_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [KEY_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 direction,
	input  logic [WORD_W-1:0]    block_word_0,
	input  logic [WORD_W-1:0]    block_word_1,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [WORD_W-1:0]    result_word_0,
	output logic [WORD_W-1:0]    result_word_1
);

	key_set_t key_q;
	blk_t     stage_blk [NUM_STAGES+1];
	logic     advance;

	// Key registers; the index covers exactly the four key words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_wr_en) begin
			key_q[cfg_index] <= cfg_data;
		end
	end

	// All round stages move together whenever the skid register has room.
	assign in_ready = advance;

	assign stage_blk[0].valid = in_valid;
	assign stage_blk[0].dir   = direction;
	assign stage_blk[0].v0    = block_word_0;
	assign stage_blk[0].v1    = block_word_1;

	// Every stage gets its own running-sum constants for both directions.
	for (genvar r = 0; r < NUM_STAGES; r++) begin : g_round
		xtea_round u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.advance   (advance),
			.odd_stage (1'(r % 2)),
			.sum_enc   (enc_sum(r)),
			.sum_dec   (dec_sum(r)),
			.key       (key_q),
			.blk_in    (stage_blk[r]),
			.blk_out   (stage_blk[r+1])
		);
	end

	xtea_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_blk    (stage_blk[NUM_STAGES]),
		.up_ready  (advance),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_v0    (result_word_0),
		.out_v1    (result_word_1)
	);

endmodule

// ===== tb/sv/xtea_block_cipher_core_tb.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the XTEA core. The driver and the receiver below
// are clocked processes. The driver feeds blocks from a queue of pending
// requests that the sequencer fills. Every transaction accepted on the input
// channel is run through a behavioral XTEA model right away. Its result is
// queued, and the receiver compares each output transaction with the oldest
// queued result.
module xtea_block_cipher_core_tb;
	import xtea_pkg::*;

	localparam int HALF_PERIOD   = 2;
	localparam int RESET_CYCLES  = 6;
	// Round stages plus the output and skid registers.
	localparam int PIPE_LATENCY  = NUM_STAGES + 2;
	localparam int HOLD_CYCLES   = 400;
	localparam int STALL_LIMIT   = 4000;
	localparam int MAX_REPORTS   = 10;
	localparam int RANDOM_BLOCKS = 415;

	typedef struct {
		logic  dir;
		word_t w0;
		word_t w1;
	} block_req_t;

	typedef struct {
		word_t r0;
		word_t r1;
	} block_res_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 cfg_wr_en     = 1'b0;
	logic [KEY_IDX_W-1:0] cfg_index     = '0;
	word_t                cfg_data      = '0;
	logic                 in_valid      = 1'b0;
	logic                 in_ready;
	logic                 direction     = DIR_ENCIPHER;
	word_t                block_word_0  = '0;
	word_t                block_word_1  = '0;
	logic                 out_valid;
	logic                 out_ready     = 1'b0;
	word_t                result_word_0;
	word_t                result_word_1;

	// Blocks waiting to be offered, and the results the core still owes us.
	block_req_t pending_blocks[$];
	block_res_t cipher_outs_due[$];

	// Our own copy of the key; it tracks every write on the config port.
	key_set_t key_copy = '0;

	// Idle rates in percent, set by the sequencer per phase.
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	// The sequencer raises hold_request once; the receiver then holds off
	// for HOLD_CYCLES, counting them down itself.
	logic hold_request = 1'b0;
	logic hold_done    = 1'b0;
	int   hold_left    = 0;

	int blocks_in     = 0;
	int deciphered    = 0;
	int results_seen  = 0;
	int mismatches    = 0;
	int key_settings  = 1;
	int stall_cycles  = 0;
	int backpressured = 0;

	xtea_block_cipher_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.direction     (direction),
		.block_word_0  (block_word_0),
		.block_word_1  (block_word_1),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result_word_0 (result_word_0),
		.result_word_1 (result_word_1)
	);

	always #HALF_PERIOD clk = ~clk;

	// XTEA mixing term: ((v << 4) ^ (v >> 5)) + v with logical shifts.
	function automatic word_t feistel_mix(input word_t v);
		return ((v << 4) ^ (v >> 5)) + v;
	endfunction

	// Behavioral XTEA, looping CYCLE_COUNT times. All sums wrap at 32 bits. When
	// enciphering, the first half-round of a cycle picks its key word with
	// sum[1:0] and the second with sum[12:11]; deciphering reverses that order
	// and starts the sum at DELTA * CYCLE_COUNT, which also wraps.
	function automatic block_res_t xtea_crypt(input logic dir, input word_t w0,
			input word_t w1, input key_set_t key);
		word_t      a;
		word_t      b;
		word_t      s;
		block_res_t r;
		a = w0;
		b = w1;
		if (dir == DIR_ENCIPHER) begin
			s = '0;
			for (int c = 0; c < CYCLE_COUNT; c++) begin
				a = a + (feistel_mix(b) ^ (s + key[s[1:0]]));
				s = s + DELTA;
				b = b + (feistel_mix(a) ^ (s + key[s[12:11]]));
			end
		end else begin
			s = DELTA * word_t'(CYCLE_COUNT);
			for (int c = 0; c < CYCLE_COUNT; c++) begin
				b = b - (feistel_mix(a) ^ (s + key[s[12:11]]));
				s = s - DELTA;
				a = a - (feistel_mix(b) ^ (s + key[s[1:0]]));
			end
		end
		r.r0 = a;
		r.r1 = b;
		return r;
	endfunction

	// Counts a failure, and prints it while there are few of them.
	task automatic report_failure(input string what, input word_t want, input word_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("[%0t] %s: expected %08h, got %08h", $realtime, what, want, got);
		end
	endtask

	// Driver. A block stays on the bus, unchanged, until it is taken; a new
	// one may follow in the cycle right after the previous transaction completes.
	always @(posedge clk or negedge arst_n) begin : sender
		block_req_t nxt;
		if (!arst_n) begin
			in_valid     <= 1'b0;
			direction    <= DIR_ENCIPHER;
			block_word_0 <= '0;
			block_word_1 <= '0;
		end else begin
			if (in_valid && in_ready) begin
				cipher_outs_due.push_back(xtea_crypt(direction, block_word_0, block_word_1,
					key_copy));
				blocks_in++;
				if (direction == DIR_DECIPHER) begin
					deciphered++;
				end
			end
			// The bus is free for a new block when nothing was on it or
			// when the block on it was just accepted.
			if (!in_valid || in_ready) begin
				if (pending_blocks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_blocks.pop_front();
					in_valid     <= 1'b1;
					direction    <= nxt.dir;
					block_word_0 <= nxt.w0;
					block_word_1 <= nxt.w1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver. It checks every output transaction against the oldest result
	// still owed, and then decides whether it is ready in the next cycle.
	always @(posedge clk or negedge arst_n) begin : receiver
		block_res_t due;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (cipher_outs_due.size() == 0) begin
					report_failure("result with no block outstanding", '0, result_word_0);
				end else begin
					due = cipher_outs_due.pop_front();
					if (result_word_0 !== due.r0) begin
						report_failure("result_word_0", due.r0, result_word_0);
					end
					if (result_word_1 !== due.r1) begin
						report_failure("result_word_1", due.r1, result_word_1);
					end
				end
			end
			if (hold_request && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog. The long hold-off stalls both channels for less than the
	// limit; a hang stalls them forever.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_ready) begin
				backpressured++;
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Timed out: no transaction on either channel for %0d cycles, "
					, STALL_LIMIT, "%0d results still owed.", cipher_outs_due.size());
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic add_block(input logic dir, input word_t w0, input word_t w1);
		block_req_t b;
		b.dir = dir;
		b.w0  = w0;
		b.w1  = w1;
		pending_blocks.push_back(b);
	endtask

	// Mostly random words, with the edge patterns mixed in.
	function automatic word_t pick_word();
		case ($urandom_range(7))
			0:       return '0;
			1:       return '1;
			2:       return word_t'(1) << $urandom_range(WORD_W - 1);
			default: return $urandom;
		endcase
	endfunction

	// Random traffic. Most of it comes as pairs: a block is enciphered and
	// the predicted ciphertext is sent back to be deciphered.
	task automatic queue_random(input int n);
		int         left;
		word_t      a;
		word_t      b;
		block_res_t c;
		left = n;
		while (left > 0) begin
			a = pick_word();
			b = pick_word();
			case ($urandom_range(9))
				0, 1, 2, 3: begin
					add_block(DIR_ENCIPHER, a, b);
					left--;
				end
				4, 5, 6, 7: begin
					c = xtea_crypt(DIR_ENCIPHER, a, b, key_copy);
					add_block(DIR_ENCIPHER, a, b);
					add_block(DIR_DECIPHER, c.r0, c.r1);
					left -= 2;
				end
				default: begin
					add_block(DIR_DECIPHER, a, b);
					left--;
				end
			endcase
		end
	endtask

	// Waits until every block has been taken and every result has come back.
	task automatic wait_drained();
		while (pending_blocks.size() != 0 || in_valid || cipher_outs_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	// Writes all four key words, one after another, while the core is empty.
	task automatic load_key(input key_set_t k);
		for (int i = 0; i < NUM_KEY_WORDS; i++) begin
			@(posedge clk);
			cfg_wr_en <= 1'b1;
			cfg_index <= KEY_IDX_W'(i);
			cfg_data  <= k[i];
			key_copy[i] = k[i];
			@(posedge clk);
			cfg_wr_en <= 1'b0;
		end
		key_settings++;
		@(negedge clk);
	endtask

	// Sequencer: directed blocks under a few fixed keys, then three random
	// phases with different keys and different idle patterns.
	initial begin : sequencer
		key_set_t   k;
		block_res_t c;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// The all-zero key straight out of reset, with extreme blocks.
		add_block(DIR_ENCIPHER, '0, '0);
		add_block(DIR_DECIPHER, '0, '0);
		add_block(DIR_ENCIPHER, '1, '1);
		add_block(DIR_DECIPHER, '1, '1);
		add_block(DIR_ENCIPHER, '0, '1);
		add_block(DIR_DECIPHER, 32'h8000_0000, 32'h0000_0001);
		add_block(DIR_ENCIPHER, 32'haaaa_aaaa, 32'h5555_5555);
		add_block(DIR_DECIPHER, 32'h5555_5555, 32'haaaa_aaaa);
		wait_drained();

		// The all-ones key.
		load_key('1);
		add_block(DIR_ENCIPHER, '0, '0);
		add_block(DIR_DECIPHER, '1, '1);
		add_block(DIR_ENCIPHER, 32'ha5a5_a5a5, 32'h0000_0000);
		add_block(DIR_DECIPHER, 32'h5a5a_5a5a, 32'hffff_ffff);
		wait_drained();

		// A byte-ramp key, with one block sent through both directions.
		k[0] = 32'h0001_0203;
		k[1] = 32'h0405_0607;
		k[2] = 32'h0809_0a0b;
		k[3] = 32'h0c0d_0e0f;
		load_key(k);
		c = xtea_crypt(DIR_ENCIPHER, 32'h4142_4344, 32'h4546_4748, key_copy);
		add_block(DIR_ENCIPHER, 32'h4142_4344, 32'h4546_4748);
		add_block(DIR_DECIPHER, c.r0, c.r1);
		add_block(DIR_DECIPHER, '0, '0);
		add_block(DIR_ENCIPHER, '1, '0);
		wait_drained();

		// Random key; the sender rarely idles and the receiver mostly does.
		for (int i = 0; i < NUM_KEY_WORDS; i++) begin
			k[i] = $urandom;
		end
		load_key(k);
		send_idle_pct = 7;
		recv_idle_pct = 82;
		queue_random(RANDOM_BLOCKS);
		wait_drained();

		// Mixed extreme key; now the sender mostly idles.
		k[0] = '0;
		k[1] = '1;
		k[2] = $urandom;
		k[3] = 32'h8000_0000;
		load_key(k);
		send_idle_pct = 82;
		recv_idle_pct = 7;
		queue_random(RANDOM_BLOCKS);
		wait_drained();

		// Random key at full rate. Partway in, the receiver holds off long
		// enough for the pipeline to fill and push back on the sender.
		for (int i = 0; i < NUM_KEY_WORDS; i++) begin
			k[i] = $urandom;
		end
		load_key(k);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random(RANDOM_BLOCKS);
		repeat (20) @(negedge clk);
		hold_request = 1'b1;
		wait_drained();

		// Give any stray result time to show up before the verdict.
		repeat (PIPE_LATENCY + 8) @(negedge clk);

		if (cipher_outs_due.size() != 0) begin
			$display("%0d results never arrived.", cipher_outs_due.size());
		end
		$display("Run covered %0d blocks (%0d deciphered) under %0d keys; %0d results checked.",
			blocks_in, deciphered, key_settings, results_seen);
		$display("The input was pushed back for %0d cycles; %0d failures were found.",
			backpressured, mismatches);
		if (mismatches == 0 && cipher_outs_due.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
